// ===== rtl/hdlcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hdlcf_pkg;

    // Line constants
    localparam logic [7:0] HDLC_FLAG = 8'h7E;
    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam int         BYTE_BITS = 8;

    // Queue depth; one item causes at most four results (flag, byte, tail, flag or two bytes, tail, flag)
    localparam int MAX_RES = 5;

    // Bits after stuffing of one byte, and their sum with held bits
    localparam int STUFF_W = 10;
    localparam int WORD_W  = 17;

    // One queued result
    typedef struct packed {
        logic [7:0] line_byte;
        logic       is_flag;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/hdlc_bit_stuffing_framer.sv =====
// HDLC bit-stuffing framer.
// Input channel: i_in_valid / o_in_ready move one transaction of a payload
// byte (i_data_byte, sent MSB first) and a last-of-frame mark (i_frame_last).
// Output channel: o_out_valid / i_out_ready move one line byte per
// transaction with o_is_flag (opening or closing 0x7E) and o_run_last
// (last result of the input item).
// Each accepted byte is stuffed and packed in the cycle it is accepted; its
// 1 to 4 results are loaded into a short result queue and the first one is
// shown on the next cycle. The queue drains one result per cycle while
// i_out_ready is high; a byte inside a frame gives one or two results.
// The next item is accepted once the queue is empty or in the same cycle
// the last queued result is taken.
// Reset (i_rst_n low at a clock edge) empties the queue and returns the
// framer to "opening flag not sent" with no held bits and no ones run.
// When the receiver stalls, the current result holds steady and the input
// side stays not ready until the queue is down to its final entry and
// that entry is being taken.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_bit_stuffing_framer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_line_byte,
    output logic            o_is_flag,
    output logic            o_run_last
);
    import hdlcf_pkg::*;

    // Framer state
    logic                r_frame_open, n_frame_open;
    logic [2:0]          r_ones_run,   n_ones_run;
    logic [7:0]          r_acc,        n_acc;
    logic [2:0]          r_held,       n_held;

    // Result queue, head at entry 0
    t_res                r_list [MAX_RES];
    t_res                n_list [MAX_RES];
    logic [2:0]          r_cnt,        n_cnt;

    logic                in_acc;
    logic                out_pop;

    // Stuffing and packing signals
    logic [STUFF_W-1:0]  stuffed;
    logic [3:0]          stuffed_len;
    logic [2:0]          run;
    logic [WORD_W-1:0]   word;
    logic [4:0]          total;
    logic [7:0]          byte_a;
    logic [7:0]          byte_b;
    logic [2:0]          rem;
    logic [7:0]          acc_left;
    t_res                new_list [MAX_RES];
    logic [2:0]          k;

    // Handshakes
    assign o_out_valid = (r_cnt != 3'd0);
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    assign o_line_byte = r_list[0].line_byte;
    assign o_is_flag   = r_list[0].is_flag;
    assign o_run_last  = (r_cnt == 3'd1);

    // Bit stuffing of the incoming byte, MSB first
    always_comb begin
        stuffed     = '0;
        stuffed_len = '0;
        run         = r_ones_run;
        for (int b = 7; b >= 0; b--) begin
            stuffed     = {stuffed[STUFF_W-2:0], i_data_byte[b]};
            stuffed_len = stuffed_len + 4'd1;
            if (i_data_byte[b]) begin
                run = run + 3'd1;
                if (run == STUFF_RUN) begin
                    stuffed     = {stuffed[STUFF_W-2:0], 1'b0};
                    stuffed_len = stuffed_len + 4'd1;
                    run         = '0;
                end
            end else begin
                run = '0;
            end
        end
    end

    // Join held bits with the stuffed bits and cut out full bytes
    always_comb begin
        word   = (WORD_W'(r_acc) << stuffed_len) | WORD_W'(stuffed);
        total  = 5'(r_held) + 5'(stuffed_len);
        byte_a = 8'(word >> (total - 5'd8));
        byte_b = 8'(word >> (total - 5'd16));
        if (total >= 5'd16) begin
            rem = 3'(total - 5'd16);
        end else if (total >= 5'(BYTE_BITS)) begin
            rem = 3'(total - 5'd8);
        end else begin
            rem = 3'(total);
        end
        acc_left = 8'(word) & 8'((9'd1 << rem) - 9'd1);
    end

    // Result list for the incoming item
    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            new_list[i] = '0;
        end
        k = '0;
        if (!r_frame_open) begin
            new_list[k] = '{line_byte: HDLC_FLAG, is_flag: 1'b1};
            k           = k + 3'd1;
        end
        if (total >= 5'd16) begin
            new_list[k] = '{line_byte: byte_a, is_flag: 1'b0};
            k           = k + 3'd1;
            new_list[k] = '{line_byte: byte_b, is_flag: 1'b0};
            k           = k + 3'd1;
        end else if (total >= 5'(BYTE_BITS)) begin
            new_list[k] = '{line_byte: byte_a, is_flag: 1'b0};
            k           = k + 3'd1;
        end
        if (i_frame_last) begin
            if (rem != 3'd0) begin
                new_list[k] = '{line_byte: acc_left, is_flag: 1'b0};
                k           = k + 3'd1;
            end
            new_list[k] = '{line_byte: HDLC_FLAG, is_flag: 1'b1};
            k           = k + 3'd1;
        end
    end

    // Next state for framer and queue
    always_comb begin
        n_frame_open = r_frame_open;
        n_ones_run   = r_ones_run;
        n_acc        = r_acc;
        n_held       = r_held;
        n_list       = r_list;
        n_cnt        = r_cnt;
        if (out_pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                n_list[i] = r_list[i+1];
            end
            n_cnt = r_cnt - 3'd1;
        end
        if (in_acc) begin
            n_list = new_list;
            n_cnt  = k;
            if (i_frame_last) begin
                n_frame_open = 1'b0;
                n_ones_run   = '0;
                n_acc        = '0;
                n_held       = '0;
            end else begin
                n_frame_open = 1'b1;
                n_ones_run   = run;
                n_acc        = acc_left;
                n_held       = rem;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_ones_run   <= '0;
            r_acc        <= '0;
            r_held       <= '0;
            r_cnt        <= '0;
        end else begin
            r_frame_open <= n_frame_open;
            r_ones_run   <= n_ones_run;
            r_acc        <= n_acc;
            r_held       <= n_held;
            r_cnt        <= n_cnt;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

endmodule

`default_nettype wire

// ===== rtl/hdlcf_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdlcf_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_line_byte,
    input wire logic       o_is_flag,
    input wire logic       o_run_last
);
    import hdlcf_pkg::*;

    // Queue is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // A flag result always carries the flag pattern
    a_flag_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_flag |-> o_line_byte == HDLC_FLAG)
        else $error("flag result with wrong byte");

    // Every item causes at least one result
    a_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("item produced no result");

    // No new item while more than one result is still queued
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> !o_in_ready)
        else $error("input ready with results pending");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_line_byte) && $stable(o_is_flag)
            && $stable(o_run_last))
        else $error("stalled result changed");

endmodule

bind hdlc_bit_stuffing_framer hdlcf_chk u_hdlcf_chk (.*);

`default_nettype wire

// ===== bench/hdlc_bit_stuffing_framer_tb.sv =====
`timescale 1ns / 1ps

module hdlc_bit_stuffing_framer_tb;
    import hdlcf_pkg::*;

    // One line byte as seen on the output channel
    typedef struct packed {
        logic [7:0] line_byte;
        logic       is_flag;
        logic       run_last;
    } t_line_res;

    // One stimulus row; n_typed > 0 means the results are written out by hand
    typedef struct packed {
        logic [7:0]      data;
        logic            last;
        logic [2:0]      n_typed;
        t_line_res [3:0] typed;
    } t_stim_row;

    localparam int N_RANDOM  = 150;
    localparam int CALM_TAIL = 30;
    localparam int LONG_HOLD = 40;
    localparam int DRAIN_CYC = 16;

    localparam t_line_res OPEN_FLAG  = {HDLC_FLAG, 1'b1, 1'b0};
    localparam t_line_res CLOSE_FLAG = {HDLC_FLAG, 1'b1, 1'b1};
    localparam t_line_res NO_RES     = '0;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       i_frame_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_line_byte;
    logic       o_is_flag;
    logic       o_run_last;

    hdlc_bit_stuffing_framer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_byte  (o_line_byte),
        .o_is_flag    (o_is_flag),
        .o_run_last   (o_run_last)
    );

    // Framer state mirror, starts at reset values
    logic       fr_open  = 1'b0;
    logic [2:0] ones_cnt = '0;
    logic [7:0] acc_bits = '0;
    logic [2:0] acc_cnt  = '0;

    t_line_res item_res_q [$];
    t_line_res line_exp_q [$];
    t_stim_row stim_tab [$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;

    int n_items   = 0;
    int n_frames  = 0;
    int n_checked = 0;
    int n_fail    = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset, once at the start
    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic stage_byte(input logic [7:0] b, input logic f);
        t_line_res e;
        e = {b, f, 1'b0};
        item_res_q.insert(item_res_q.size(), e);
    endtask

    // Shift one line bit in; a full byte goes out right away
    task automatic shift_bit(input logic b);
        acc_bits = {acc_bits[6:0], b};
        if (acc_cnt == 3'd7) begin
            stage_byte(acc_bits, 1'b0);
            acc_bits = '0;
            acc_cnt  = '0;
        end else begin
            acc_cnt = acc_cnt + 3'd1;
        end
    endtask

    // Encode one payload byte into item_res_q (run_last not yet set)
    task automatic frame_byte(input logic [7:0] d, input logic last);
        item_res_q.delete();
        if (!fr_open) begin
            stage_byte(HDLC_FLAG, 1'b1);
            fr_open = 1'b1;
        end
        for (int i = 7; i >= 0; i--) begin
            shift_bit(d[i]);
            if (d[i]) begin
                ones_cnt = ones_cnt + 3'd1;
                // zero insertion after five ones
                if (ones_cnt == STUFF_RUN) begin
                    shift_bit(1'b0);
                    ones_cnt = '0;
                end
            end else begin
                ones_cnt = '0;
            end
        end
        if (last) begin
            // partial tail goes out as it stands, low bits, no padding
            if (acc_cnt != 3'd0)
                stage_byte(acc_bits, 1'b0);
            stage_byte(HDLC_FLAG, 1'b1);
            acc_bits = '0;
            acc_cnt  = '0;
            ones_cnt = '0;
            fr_open  = 1'b0;
        end
    endtask

    // Queue the results of one accepted transaction
    task automatic expect_item(input t_stim_row r);
        t_line_res e;
        frame_byte(r.data, r.last);
        if (r.n_typed != 0) begin
            for (int k = 0; k < r.n_typed; k++)
                line_exp_q.insert(line_exp_q.size(), r.typed[k]);
        end else begin
            for (int k = 0; k < item_res_q.size(); k++) begin
                e = item_res_q[k];
                e.run_last = (k == item_res_q.size() - 1);
                line_exp_q.insert(line_exp_q.size(), e);
            end
        end
    endtask

    task automatic add_row(input logic [7:0] d, input logic l, input int n,
                           input t_line_res r0, input t_line_res r1,
                           input t_line_res r2, input t_line_res r3);
        t_stim_row row;
        row          = '0;
        row.data     = d;
        row.last     = l;
        row.n_typed  = n[2:0];
        row.typed[0] = r0;
        row.typed[1] = r1;
        row.typed[2] = r2;
        row.typed[3] = r3;
        stim_tab.insert(stim_tab.size(), row);
    endtask

    // Offer one transaction, with an optional idle burst ahead of it
    task automatic send_row(input t_stim_row r);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= r.data;
        i_frame_last <= r.last;
        do @(posedge i_clk); while (!o_in_ready);
        expect_item(r);
        n_items++;
        if (r.last)
            n_frames++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        i_out_ready <= 1'b0;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Output check against the oldest expectation
    always @(posedge i_clk) begin : line_check
        t_line_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_exp_q.size() == 0) begin
                $error("unexpected line byte %02h (flag %0b last %0b)",
                       o_line_byte, o_is_flag, o_run_last);
                n_fail++;
            end else begin
                want = line_exp_q.pop_front();
                if (o_line_byte !== want.line_byte) begin
                    $error("line_byte: expected %02h, got %02h", want.line_byte, o_line_byte);
                    n_fail++;
                end
                if (o_is_flag !== want.is_flag) begin
                    $error("is_flag: expected %0b, got %0b", want.is_flag, o_is_flag);
                    n_fail++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                    n_fail++;
                end
                n_checked++;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_stim_row row;
        int        flen;
        int        k;
        i_in_valid   <= 1'b0;
        i_data_byte  <= '0;
        i_frame_last <= 1'b0;

        // all-zero single-byte frame: no stuffing, no tail
        add_row(8'h00, 1'b1, 3, OPEN_FLAG, {8'h00, 1'b0, 1'b0}, CLOSE_FLAG, NO_RES);
        // all-ones single-byte frame: one stuffed zero, one-bit tail
        add_row(8'hFF, 1'b1, 4, OPEN_FLAG, {8'hFB, 1'b0, 1'b0}, {8'h01, 1'b0, 1'b0},
                CLOSE_FLAG);
        // long frame: ones runs across byte boundaries, flag-like payload
        add_row(8'h7E, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hFF, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hFF, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h0F, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hF0, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hF8, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h1F, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h3E, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h7C, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hAA, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h55, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h01, 1'b1, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        // short frames: fresh start after each frame end
        add_row(8'h80, 1'b1, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h1F, 1'b1, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hFF, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hFF, 1'b1, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'hE0, 1'b0, 0, NO_RES, NO_RES, NO_RES, NO_RES);
        add_row(8'h00, 1'b1, 0, NO_RES, NO_RES, NO_RES, NO_RES);

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        foreach (stim_tab[j])
            send_row(stim_tab[j]);

        // random frames of 1 to 6 bytes, ones-heavy to hit stuffing
        k = 0;
        while (k < N_RANDOM) begin
            flen = $urandom_range(1, 6);
            for (int j = 0; j < flen; j++) begin
                tx_idle_en = !(k >= 40 && k < 56) && (k < N_RANDOM - CALM_TAIL);
                rx_idle_en = (k < N_RANDOM - CALM_TAIL);
                if (k == 40)
                    hold_req = 1'b1;
                // sender pause until the output side has drained
                if (k == 100) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (line_exp_q.size() != 0) @(posedge i_clk);
                end
                row = '0;
                case ($urandom_range(0, 3))
                    0: row.data = 8'hFF;
                    1: row.data = 8'($urandom | $urandom);
                    default: row.data = 8'($urandom_range(0, 255));
                endcase
                row.last = (j == flen - 1);
                send_row(row);
                k++;
            end
        end
        i_in_valid <= 1'b0;

        while (line_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Sent %0d payload bytes in %0d frames, checked %0d line bytes",
                 n_items, n_frames, n_checked);
        $display("Run included stuffing runs, partial tails, a long output stall and a drain pause");
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hdlcf_pkg.sv
rtl/hdlc_bit_stuffing_framer.sv
rtl/hdlcf_chk.sv
bench/hdlc_bit_stuffing_framer_tb.sv
